// File: rtl/sorted_array_priority_queue_top_assert.svh
// ----------------------------------------------------------------------------
// sorted array priority queue assertion macros
// shared property shells for the queue checks
// ----------------------------------------------------------------------------
`ifndef SORTED_ARRAY_PRIORITY_QUEUE_TOP_ASSERT_SVH
`define SORTED_ARRAY_PRIORITY_QUEUE_TOP_ASSERT_SVH

// condition that holds at every edge outside reset
`define SAPQ_CHECK(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error(msg);

// condition that must follow in the cycle after a trigger
`define SAPQ_CHECK_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/sapq_pkg.sv
// ----------------------------------------------------------------------------
// sapq_pkg
// sizes, codes and the command struct shared by the queue and its cells
// ----------------------------------------------------------------------------
package sapq_pkg;

   localparam int DEPTH   = 16;
   localparam int CountW  = $clog2(DEPTH + 1);
   localparam int IdxW    = $clog2(DEPTH);
   localparam int ValW    = 32;
   localparam int FillW   = 5;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_OVERFLOW  = 2'd1,
      ST_UNDERFLOW = 2'd2
   } status_type;

   typedef enum logic {
      ACT_ENQUEUE = 1'b0,
      ACT_DEQUEUE = 1'b1
   } action_type;

   // broadcast to every cell in the row
   typedef struct packed {
      logic                   update;
      logic                   dequeue;
      logic signed [ValW-1:0] value;
   } cell_cmd_type;

endpackage

// File: rtl/sapq_cell.sv
// ----------------------------------------------------------------------------
// sapq_cell
// one slot of the sorted row: compares, shifts right on insert, left on remove
// ----------------------------------------------------------------------------
module sapq_cell
   import sapq_pkg::*;
(
   input  logic                   clock,
   input  logic [IdxW-1:0]        cell_idx,
   input  logic [CountW-1:0]      count,
   input  cell_cmd_type           cmd,
   input  logic signed [ValW-1:0] left_data,
   input  logic                   left_lt,
   input  logic signed [ValW-1:0] right_data,
   output logic signed [ValW-1:0] data,
   output logic                   lt
);

   logic signed [ValW-1:0] data_ff;
   logic signed [ValW-1:0] data_in;
   logic [CountW-1:0]      idx_ext;
   logic                   in_use;
   logic                   at_tail;
   logic signed [ValW-1:0] insert_val;

   assign idx_ext = CountW'(cell_idx);
   assign in_use  = idx_ext < count;
   assign at_tail = idx_ext == count;

   // strictly less: equal values stay ahead of the new one
   assign lt = in_use && (cmd.value < data_ff);

   // take the left neighbor when the new value lands further left
   assign insert_val = left_lt ? left_data : cmd.value;

   always_comb begin
      data_in = data_ff;
      if (cmd.update) begin
         if (cmd.dequeue) begin
            data_in = right_data;
         end else if ((in_use && lt) || at_tail) begin
            data_in = insert_val;
         end
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

// File: rtl/sorted_array_priority_queue_top.sv
// ----------------------------------------------------------------------------
// sorted_array_priority_queue_top
// min-priority queue of signed values kept ascending in a row of cells
// ----------------------------------------------------------------------------
//
//  channel  ports                                   handshake
//  -------  --------------------------------------  -------------------------
//  request  req_action, req_value_in                start high, busy low
//  result   rsp_status, rsp_value_out,              rsp_strobe, one cycle
//           rsp_fill_level
//
//  one request per cycle, every cycle: busy stays low
//  each result shows in the cycle after its request, for one cycle only
//  all cells compare against the request value in parallel and shift in the
//  same edge that registers the result
//  synchronous active-high reset empties the queue and drops the strobe
//  the receiver cannot stall, so no result ever waits
//
module sorted_array_priority_queue_top
   import sapq_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic                   req_action,
   input  logic signed [ValW-1:0] req_value_in,
   output logic                   rsp_strobe,
   output logic [1:0]             rsp_status,
   output logic signed [ValW-1:0] rsp_value_out,
   output logic [FillW-1:0]       rsp_fill_level
);

`include "sorted_array_priority_queue_top_assert.svh"

   // queue occupancy
   logic [CountW-1:0]      cnt_ff;
   logic [CountW-1:0]      cnt_in;

   // registered result
   logic                   strobe_ff;
   logic                   strobe_in;
   status_type             status_ff;
   status_type             status_in;
   logic signed [ValW-1:0] value_ff;
   logic signed [ValW-1:0] value_in;
   logic [FillW-1:0]       fill_ff;
   logic [FillW-1:0]       fill_in;

   logic                   accept;
   logic                   is_full;
   logic                   is_empty;
   logic                   do_dequeue;
   cell_cmd_type           cmd;
   logic [CountW+FillW-1:0] cnt_wide;

   logic signed [ValW-1:0] cell_data [DEPTH];
   logic                   cell_lt   [DEPTH];

   // the row takes a request every cycle
   assign busy   = 1'b0;
   assign accept = start && !busy;

   assign is_full    = cnt_ff == CountW'(DEPTH);
   assign is_empty   = cnt_ff == '0;
   assign do_dequeue = req_action == ACT_DEQUEUE;

   // cells move only when the operation succeeds
   always_comb begin
      cmd.dequeue = do_dequeue;
      cmd.value   = req_value_in;
      cmd.update  = accept && (do_dequeue ? !is_empty : !is_full);
   end

   // row of cells, head at index zero
   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      logic signed [ValW-1:0] left_d;
      logic                   left_l;
      logic signed [ValW-1:0] right_d;

      if (g == 0) begin : g_head
         assign left_d = '0;
         assign left_l = 1'b0;
      end else begin : g_mid
         assign left_d = cell_data[g-1];
         assign left_l = cell_lt[g-1];
      end

      if (g == DEPTH - 1) begin : g_last
         assign right_d = '0;
      end else begin : g_inner
         assign right_d = cell_data[g+1];
      end

      sapq_cell u_cell (
         .clock      (clock),
         .cell_idx   (IdxW'(g)),
         .count      (cnt_ff),
         .cmd        (cmd),
         .left_data  (left_d),
         .left_lt    (left_l),
         .right_data (right_d),
         .data       (cell_data[g]),
         .lt         (cell_lt[g])
      );
   end

   // count and result for the request in flight
   always_comb begin
      cnt_in    = cnt_ff;
      strobe_in = accept;
      status_in = ST_OK;
      value_in  = '0;
      if (do_dequeue) begin
         if (is_empty) begin
            status_in = ST_UNDERFLOW;
         end else begin
            value_in = cell_data[0];
            cnt_in   = cnt_ff - CountW'(1);
         end
      end else begin
         if (is_full) begin
            status_in = ST_OVERFLOW;
         end else begin
            value_in = req_value_in;
            cnt_in   = cnt_ff + CountW'(1);
         end
      end
      if (!accept) begin
         cnt_in = cnt_ff;
      end
   end

   // fill level carries the whole count after the request
   assign cnt_wide = {{FillW{1'b0}}, cnt_in};
   assign fill_in  = cnt_wide[FillW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff    <= '0;
         strobe_ff <= 1'b0;
      end else begin
         cnt_ff    <= cnt_in;
         strobe_ff <= strobe_in;
      end
   end

   // result payload, no reset needed
   always_ff @(posedge clock) begin
      status_ff <= status_in;
      value_ff  <= value_in;
      fill_ff   <= fill_in;
   end

   assign rsp_strobe     = strobe_ff;
   assign rsp_status     = status_ff;
   assign rsp_value_out  = value_ff;
   assign rsp_fill_level = fill_ff;

   // checks
   `SAPQ_CHECK_NEXT(a_resp_follows_req, accept, rsp_strobe, "request without result")
   `SAPQ_CHECK(a_count_bound, cnt_ff <= CountW'(DEPTH), "count above depth")
   `SAPQ_CHECK(a_reject_keeps_count,
      !(rsp_strobe && rsp_status != ST_OK) || cnt_ff == $past(cnt_ff),
      "rejected request changed count")
   `SAPQ_CHECK(a_head_sorted,
      !(cnt_ff >= CountW'(2)) || !(cell_data[1] < cell_data[0]),
      "head entries out of order")

endmodule
